// ===== rtl/qph_pkg.sv =====
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types, codes and defaults of the quadratic probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package qph_pkg;

    // default sizes of the table
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_KEY_CHARS   = 8;
    localparam int DEF_VALUE_BITS  = 32;

    // fixed field widths
    localparam int SIZE_W  = 7;
    localparam int KEY_FW  = 64;
    localparam int VAL_FW  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = 7'd64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // command beat
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_FW-1:0] key;
        logic [VAL_FW-1:0] value;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_FW-1:0] read_value;
        logic [SIZE_W-1:0] stored_count;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/qph_mod_reduce.sv =====
// ----------------------------------------------------------------------------
// qph_mod_reduce
// One conditional subtract: reduces a value below twice the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_mod_reduce
    import qph_pkg::*;
(
    input  wire logic [SIZE_W:0]   a,
    input  wire logic [SIZE_W-1:0] m,
    output logic      [SIZE_W-1:0] r
);

    logic [SIZE_W-1:0] diff;

    // compare and subtract once, the result is below the modulus when the input is below twice it
    always_comb
    begin
        diff = a[SIZE_W-1:0] - m;
        if (a >= {1'b0, m})
        begin
            r = diff;
        end
        else
        begin
            r = a[SIZE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quadratic_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Key/value table with open addressing and quadratic probing.
// ----------------------------------------------------------------------------
// After reset the slot memory is cleared with busy high; table size writes are
// taken during it. A command is taken when start is high and busy is low. An
// unused command code answers in the next cycle. Any other command hashes the
// key one character per cycle up to the terminator of a shorter key or the
// last character, reduces the hash by bit-serial modulo by the table size,
// then probes, one slot memory read per cycle, and answers in the cycle after.
// The result shows on response for the single cycle in which done is high and
// cannot be held off, so it must be captured then.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table_core
    import qph_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_CHARS   = DEF_KEY_CHARS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire in_item_t          request,
    output logic                   done,
    output out_item_t              response,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    localparam int KEY_W  = 8 * KEY_CHARS;
    localparam int VAL_W  = (VALUE_BITS < VAL_FW) ? VALUE_BITS : VAL_FW;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HASH_W = KEY_CHARS + 8;
    localparam int CH_W   = $clog2(KEY_CHARS + 1);
    localparam int BIT_W  = $clog2(HASH_W + 1);
    localparam int MEM_W  = 1 + KEY_W + VAL_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_PROBE
    } state_t;

    // registers
    state_t              state_reg,       state_next;
    logic [SIZE_W-1:0]   table_size_reg,  table_size_next;
    logic [SIZE_W-1:0]   size_reg,        size_next;
    logic [CMD_W-1:0]    cmd_reg,         cmd_next;
    logic [KEY_W-1:0]    key_reg,         key_next;
    logic [VAL_W-1:0]    val_reg,         val_next;
    logic [KEY_W-1:0]    kshift_reg,      kshift_next;
    logic [CH_W-1:0]     chars_left_reg,  chars_left_next;
    logic [HASH_W-1:0]   hash_reg,        hash_next;
    logic [BIT_W-1:0]    bits_left_reg,   bits_left_next;
    logic [SIZE_W-1:0]   rem_reg,         rem_next;
    logic [SIZE_W-1:0]   probe_idx_reg,   probe_idx_next;
    logic [SIZE_W-1:0]   step_reg,        step_next;
    logic [SIZE_W-1:0]   issue_cnt_reg,   issue_cnt_next;
    logic                chk_vld_reg,     chk_vld_next;
    logic                chk_last_reg,    chk_last_next;
    logic [IDX_W-1:0]    chk_addr_reg,    chk_addr_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [IDX_W-1:0]    clr_cnt_reg,     clr_cnt_next;
    logic                done_reg,        done_next;
    out_item_t           result_reg,      result_next;

    // slot memory and its ports
    logic [MEM_W-1:0]    slot_mem [TABLE_DEPTH];
    logic [MEM_W-1:0]    rdata_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [MEM_W-1:0]    wr_data;

    // combinational helpers
    logic [KEY_W-1:0]    clean_key;
    logic [SIZE_W-1:0]   act_size;
    logic [7:0]          top_char;
    logic [SIZE_W:0]     red_a;
    logic [SIZE_W-1:0]   red_r;
    logic [SIZE_W:0]     step_a;
    logic [SIZE_W-1:0]   step_r;
    logic                slot_used;
    logic [KEY_W-1:0]    slot_key;
    logic [VAL_W-1:0]    slot_val;
    logic                key_hit;
    logic                issue;

    // outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign response  = result_reg;
    assign cfg_ready = 1'b1;

    // drop bytes past the key width and after the terminator
    always_comb
    begin
        logic [KEY_W-1:0] kin;
        logic             alive;
        kin   = request.key[KEY_W-1:0];
        alive = 1'b1;
        clean_key = '0;
        for (int b = KEY_CHARS - 1; b >= 0; b--)
        begin
            alive = alive & (kin[8*b +: 8] != 8'd0);
            clean_key[8*b +: 8] = alive ? kin[8*b +: 8] : 8'd0;
        end
    end

    // size in use: zero acts as one, clamp to the memory depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            act_size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            act_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            act_size = table_size_reg;
        end
    end

    // shared reducer: modulo step while reducing the hash, probe address while probing
    assign red_a = (state_reg == S_MOD)
                   ? {rem_reg, hash_reg[HASH_W-1]}
                   : ({1'b0, probe_idx_reg} + {1'b0, step_reg});

    qph_mod_reduce u_idx_reduce
    (
        .a (red_a),
        .m (size_reg),
        .r (red_r)
    );

    // odd step of the square sequence, i*i grows by 2i+1
    assign step_a = {1'b0, step_reg} + (SIZE_W + 1)'(2);

    qph_mod_reduce u_step_reduce
    (
        .a (step_a),
        .m (size_reg),
        .r (step_r)
    );

    // fields of the slot read in the previous cycle
    assign slot_used = rdata_reg[MEM_W-1];
    assign slot_key  = rdata_reg[VAL_W +: KEY_W];
    assign slot_val  = rdata_reg[VAL_W-1:0];
    assign key_hit   = (slot_key == key_reg);
    assign top_char  = kshift_reg[KEY_W-1 -: 8];
    assign issue     = (state_reg == S_PROBE) && (issue_cnt_reg < size_reg);
    assign rd_addr   = IDX_W'(probe_idx_reg);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        table_size_next  = table_size_reg;
        size_next        = size_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        kshift_next      = kshift_reg;
        chars_left_next  = chars_left_reg;
        hash_next        = hash_reg;
        bits_left_next   = bits_left_reg;
        rem_next         = rem_reg;
        probe_idx_next   = probe_idx_reg;
        step_next        = step_reg;
        issue_cnt_next   = issue_cnt_reg;
        chk_vld_next     = 1'b0;
        chk_last_next    = 1'b0;
        chk_addr_next    = chk_addr_reg;
        entry_count_next = entry_count_reg;
        clr_cnt_next     = clr_cnt_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_addr_reg;
        wr_data          = rdata_reg;

        // table size write
        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = request.command;
                    key_next        = clean_key;
                    val_next        = request.value[VAL_W-1:0];
                    size_next       = act_size;
                    kshift_next     = clean_key;
                    chars_left_next = CH_W'(KEY_CHARS);
                    hash_next       = '0;
                    if (request.command inside {CMD_INSERT, CMD_DELETE, CMD_SEARCH})
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        done_next                = 1'b1;
                        result_next.status       = ST_NOT_FOUND;
                        result_next.read_value   = '0;
                        result_next.stored_count = SIZE_W'(entry_count_reg);
                    end
                end
            end

            // one key character per cycle
            S_HASH:
            begin
                bits_left_next = BIT_W'(HASH_W);
                rem_next       = '0;
                if (top_char == 8'd0)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    hash_next       = {hash_reg[HASH_W-2:0], 1'b0} + HASH_W'(top_char);
                    kshift_next     = kshift_reg << 8;
                    chars_left_next = chars_left_reg - CH_W'(1);
                    if (chars_left_reg == CH_W'(1))
                    begin
                        state_next = S_MOD;
                    end
                end
            end

            // restoring modulo, one hash bit per cycle
            S_MOD:
            begin
                rem_next       = red_r;
                hash_next      = hash_reg << 1;
                bits_left_next = bits_left_reg - BIT_W'(1);
                if (bits_left_reg == BIT_W'(1))
                begin
                    state_next     = S_PROBE;
                    probe_idx_next = red_r;
                    step_next      = (size_reg == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                    issue_cnt_next = '0;
                end
            end

            // read one slot per cycle, check the one read before
            S_PROBE:
            begin
                if (issue)
                begin
                    probe_idx_next = red_r;
                    step_next      = step_r;
                    issue_cnt_next = issue_cnt_reg + SIZE_W'(1);
                    chk_vld_next   = 1'b1;
                    chk_last_next  = (issue_cnt_reg == size_reg - SIZE_W'(1));
                    chk_addr_next  = rd_addr;
                end

                if (chk_vld_reg)
                begin
                    result_next.read_value   = '0;
                    result_next.stored_count = SIZE_W'(entry_count_reg);
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!slot_used || key_hit)
                            begin
                                wr_en   = 1'b1;
                                wr_data = {1'b1, key_reg, val_reg};
                                if (!slot_used)
                                begin
                                    entry_count_next = entry_count_reg + CNT_W'(1);
                                    result_next.stored_count = SIZE_W'(entry_count_next);
                                end
                                state_next         = S_IDLE;
                                done_next          = 1'b1;
                                result_next.status = ST_OK;
                            end
                            else if (chk_last_reg)
                            begin
                                state_next         = S_IDLE;
                                done_next          = 1'b1;
                                result_next.status = ST_FULL;
                            end
                        end

                        CMD_DELETE:
                        begin
                            if (slot_used && key_hit)
                            begin
                                wr_en            = 1'b1;
                                wr_data          = {1'b0, slot_key, slot_val};
                                entry_count_next = entry_count_reg - CNT_W'(1);
                                result_next.stored_count = SIZE_W'(entry_count_next);
                                state_next         = S_IDLE;
                                done_next          = 1'b1;
                                result_next.status = ST_OK;
                            end
                            else if (chk_last_reg)
                            begin
                                state_next         = S_IDLE;
                                done_next          = 1'b1;
                                result_next.status = ST_NOT_FOUND;
                            end
                        end

                        CMD_SEARCH:
                        begin
                            if (slot_used && key_hit)
                            begin
                                state_next             = S_IDLE;
                                done_next              = 1'b1;
                                result_next.status     = ST_OK;
                                result_next.read_value = VAL_FW'(slot_val);
                            end
                            else if (chk_last_reg)
                            begin
                                state_next         = S_IDLE;
                                done_next          = 1'b1;
                                result_next.status = ST_NOT_FOUND;
                            end
                        end

                        default:
                        begin
                            state_next         = S_IDLE;
                            done_next          = 1'b1;
                            result_next.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            table_size_reg  <= RESET_TABLE_SIZE;
            entry_count_reg <= '0;
            clr_cnt_reg     <= '0;
            issue_cnt_reg   <= '0;
            chk_vld_reg     <= 1'b0;
            chk_last_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            table_size_reg  <= table_size_next;
            entry_count_reg <= entry_count_next;
            clr_cnt_reg     <= clr_cnt_next;
            issue_cnt_reg   <= issue_cnt_next;
            chk_vld_reg     <= chk_vld_next;
            chk_last_reg    <= chk_last_next;
            done_reg        <= done_next;
        end
    end

    // working registers without reset
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        kshift_reg     <= kshift_next;
        chars_left_reg <= chars_left_next;
        hash_reg       <= hash_next;
        bits_left_reg  <= bits_left_next;
        rem_reg        <= rem_next;
        probe_idx_reg  <= probe_idx_next;
        step_reg       <= step_next;
        chk_addr_reg   <= chk_addr_next;
        result_reg     <= result_next;
    end

    // slot memory: used bit, key and value per slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= slot_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/qph_checker.sv =====
// ----------------------------------------------------------------------------
// qph_checker
// Port-level checks of the hash table core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_checker
    import qph_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire out_item_t response
);

    logic [SIZE_W-1:0] last_count_reg;

    // count reported by the last result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (done)
        begin
            last_count_reg <= response.stored_count;
        end
    end

    // an accepted command keeps the core busy unless it answers at once
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("core not busy after an accepted command");

    // the result beat comes with the core back in idle
    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // only a successful command carries a read value
    a_value_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.status != ST_OK |-> response.read_value == '0)
        else $error("read value on a failed command");

    // a failed command leaves the entry count alone
    a_count_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.status != ST_OK |-> response.stored_count == last_count_reg)
        else $error("entry count changed by a failed command");

endmodule

bind quadratic_probe_hash_table_core qph_checker u_qph_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

`default_nettype wire
